// ===== src/uac_pkg.sv =====
// Shared constants, payload types and control structs for the unique advertiser counter.
`timescale 1ns / 1ps
`default_nettype none
package uac_pkg;

	localparam int TABLE_ENTRIES = 512;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int BINS = 256;
	localparam int BIN_W = 8;
	localparam int BCNT_W = BIN_W + 1;
	localparam int ADDR_W = 48;
	localparam int RSSI_W = 8;
	localparam int SEC_W = 32;
	localparam int BS_W = 17;
	localparam logic [BS_W-1:0] BS_RESET = BS_W'(60);
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [0:0] REG_BUCKET_SECONDS = 1'b0;
	localparam logic KIND_ADV = 1'b0;
	localparam logic KIND_TIME = 1'b1;

	typedef struct packed {
		logic kind;
		logic [ADDR_W-1:0] device_address;
		logic signed [RSSI_W-1:0] signal_strength;
		logic [SEC_W-1:0] now_seconds;
	} item_t;

	typedef struct packed {
		logic [CNT_W-1:0] unique_count;
		logic [SEC_W-1:0] bucket_begin;
		logic signed [RSSI_W-1:0] median_strength;
		logic added;
		logic dropped_full;
		logic rolled;
	} result_t;

	typedef struct packed {
		logic load;
		logic scan_init;
		logic scan_step;
		logic time_step;
		logic hist_rd;
		logic add;
		logic drop;
		logic clr_init;
		logic clr_step;
		logic med_init;
		logic med_step;
	} cmd_t;

	typedef struct packed {
		logic kind;
		logic match;
		logic scan_done;
		logic full;
		logic roll;
		logic rolled;
		logic clr_last;
		logic empty;
		logic med_found;
	} status_t;

endpackage
`default_nettype wire

// ===== src/uac_datapath.sv =====
// Datapath: address table, strength histogram, bucket timing and median search.
`timescale 1ns / 1ps
`default_nettype none
module uac_datapath (
	input wire logic clk,
	input wire logic arst_n,
	input wire uac_pkg::cmd_t cmd,
	input wire uac_pkg::item_t item,
	input wire logic [uac_pkg::BS_W-1:0] bucket_seconds,
	output uac_pkg::status_t status,
	output uac_pkg::result_t result
);

	uac_pkg::item_t item_q;
	logic [uac_pkg::CNT_W-1:0] count_q;
	logic [uac_pkg::SEC_W-1:0] start_q;
	logic added_q, dropped_q, rolled_q;
	logic [uac_pkg::CNT_W-1:0] idx_q;
	logic scan_pend_s1;
	logic [uac_pkg::ADDR_W-1:0] addr_rd_s1;
	logic [uac_pkg::ADDR_W-1:0] addr_mem [uac_pkg::TABLE_ENTRIES];
	logic [uac_pkg::CNT_W-1:0] hist_mem [uac_pkg::BINS];
	logic [uac_pkg::CNT_W-1:0] hist_rd_s1;
	logic [uac_pkg::BCNT_W-1:0] bin_q;
	logic [uac_pkg::BIN_W-1:0] bin_s1;
	logic med_pend_s1;
	logic [uac_pkg::CNT_W-1:0] acc_q;
	logic [uac_pkg::RSSI_W-1:0] med_q;

	logic [uac_pkg::BIN_W-1:0] own_bin;
	logic [uac_pkg::BIN_W-1:0] hist_raddr;
	logic [uac_pkg::SEC_W-1:0] start_eff;
	logic [uac_pkg::SEC_W-1:0] diff;
	logic roll;
	logic [uac_pkg::CNT_W:0] sum;
	logic med_found;

	assign own_bin = item_q.signal_strength ^ uac_pkg::BIN_W'(8'h80);
	assign hist_raddr = cmd.hist_rd ? own_bin : bin_q[uac_pkg::BIN_W-1:0];
	assign start_eff = (start_q == '0) ? item_q.now_seconds : start_q;
	assign diff = item_q.now_seconds - start_eff;
	assign roll = diff >= uac_pkg::SEC_W'(bucket_seconds);
	assign sum = {1'b0, acc_q} + {1'b0, hist_rd_s1};
	assign med_found = med_pend_s1 && (sum > {2'b00, count_q[uac_pkg::CNT_W-1:1]});

	always_ff @(posedge clk) begin
		addr_rd_s1 <= addr_mem[idx_q[uac_pkg::IDX_W-1:0]];
		if (cmd.add) begin
			addr_mem[count_q[uac_pkg::IDX_W-1:0]] <= item_q.device_address;
		end
	end

	always_ff @(posedge clk) begin
		hist_rd_s1 <= hist_mem[hist_raddr];
		bin_s1 <= bin_q[uac_pkg::BIN_W-1:0];
		if (cmd.add) begin
			hist_mem[own_bin] <= hist_rd_s1 + uac_pkg::CNT_W'(1);
		end else if (cmd.clr_step) begin
			hist_mem[bin_q[uac_pkg::BIN_W-1:0]] <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (med_found && cmd.med_step) begin
			med_q <= bin_s1 ^ uac_pkg::RSSI_W'(8'h80);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			start_q <= '0;
			added_q <= 1'b0;
			dropped_q <= 1'b0;
			rolled_q <= 1'b0;
			idx_q <= '0;
			scan_pend_s1 <= 1'b0;
			bin_q <= '0;
			med_pend_s1 <= 1'b0;
			acc_q <= '0;
		end else begin
			if (cmd.load) begin
				added_q <= 1'b0;
				dropped_q <= 1'b0;
				rolled_q <= 1'b0;
			end
			if (cmd.scan_init) begin
				idx_q <= '0;
				scan_pend_s1 <= 1'b0;
			end else if (cmd.scan_step) begin
				if (idx_q < count_q) begin
					idx_q <= idx_q + uac_pkg::CNT_W'(1);
					scan_pend_s1 <= 1'b1;
				end else begin
					scan_pend_s1 <= 1'b0;
				end
			end
			if (cmd.time_step) begin
				start_q <= roll ? item_q.now_seconds : start_eff;
				rolled_q <= roll;
				if (roll) begin
					count_q <= '0;
				end
			end
			if (cmd.add) begin
				count_q <= count_q + uac_pkg::CNT_W'(1);
				added_q <= 1'b1;
			end
			if (cmd.drop) begin
				dropped_q <= 1'b1;
			end
			if (cmd.clr_init || cmd.med_init) begin
				bin_q <= '0;
				med_pend_s1 <= 1'b0;
				acc_q <= '0;
			end else if (cmd.clr_step) begin
				bin_q <= bin_q + uac_pkg::BCNT_W'(1);
			end else if (cmd.med_step) begin
				if (bin_q < uac_pkg::BCNT_W'(uac_pkg::BINS)) begin
					bin_q <= bin_q + uac_pkg::BCNT_W'(1);
					med_pend_s1 <= 1'b1;
				end else begin
					med_pend_s1 <= 1'b0;
				end
				if (med_pend_s1) begin
					acc_q <= sum[uac_pkg::CNT_W-1:0];
				end
			end
		end
	end

	always_comb begin
		status.kind = item_q.kind;
		status.match = scan_pend_s1 && (addr_rd_s1 == item_q.device_address);
		status.scan_done = !scan_pend_s1 && (idx_q >= count_q);
		status.full = count_q == uac_pkg::CNT_W'(uac_pkg::TABLE_ENTRIES);
		status.roll = roll;
		status.rolled = rolled_q;
		status.clr_last = bin_q == uac_pkg::BCNT_W'(uac_pkg::BINS - 1);
		status.empty = count_q == '0;
		status.med_found = med_found;
	end

	always_comb begin
		result.unique_count = count_q;
		result.bucket_begin = start_q;
		result.median_strength = (count_q == '0) ? '0 : med_q;
		result.added = added_q;
		result.dropped_full = dropped_q;
		result.rolled = rolled_q;
	end

endmodule
`default_nettype wire

// ===== src/uac_ctrl.sv =====
// Controller state machine that sequences lookup, insert, bucket roll and median search.
`timescale 1ns / 1ps
`default_nettype none
module uac_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire uac_pkg::status_t status,
	output uac_pkg::cmd_t cmd,
	output logic busy,
	output logic done
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_HRD,
		S_HWR,
		S_CLEAR,
		S_MINIT,
		S_MED,
		S_DONE
	} state_t;

	state_t state_q, state_n;

	always_comb begin
		state_n = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_n = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (status.kind == uac_pkg::KIND_TIME) begin
					cmd.time_step = 1'b1;
					if (status.roll) begin
						cmd.clr_init = 1'b1;
						state_n = S_CLEAR;
					end else begin
						state_n = S_MINIT;
					end
				end else begin
					cmd.scan_init = 1'b1;
					state_n = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.match) begin
					state_n = S_MINIT;
				end else if (status.scan_done) begin
					if (status.full) begin
						cmd.drop = 1'b1;
						state_n = S_MINIT;
					end else begin
						state_n = S_HRD;
					end
				end
			end
			S_HRD: begin
				cmd.hist_rd = 1'b1;
				state_n = S_HWR;
			end
			S_HWR: begin
				cmd.add = 1'b1;
				state_n = S_MINIT;
			end
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (status.clr_last) begin
					state_n = status.rolled ? S_DONE : S_IDLE;
				end
			end
			S_MINIT: begin
				cmd.med_init = 1'b1;
				state_n = status.empty ? S_DONE : S_MED;
			end
			S_MED: begin
				cmd.med_step = 1'b1;
				if (status.med_found) begin
					state_n = S_DONE;
				end
			end
			S_DONE: begin
				state_n = S_IDLE;
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			done <= 1'b0;
		end else begin
			state_q <= state_n;
			done <= state_q == S_DONE;
		end
	end

	assign busy = state_q != S_IDLE;

endmodule
`default_nettype wire

// ===== src/unique_advertiser_counter.sv =====
// Top level of the unique advertiser counter: register port, controller and datapath.
//
// Channel  Ports                               Transfer
// item     start, busy, item                   accepted when start is high and busy is low
// result   done, result                        valid for the single cycle that done is high
// config   psel, penable, pwrite, paddr, ...   APB write in the access cycle, pready tied high
//
// An advertisement runs a serial address lookup through the single table read port, then a
// histogram read and write to insert a new address, then the median search unless the table
// is empty. A dispatch state comes first and a final state last; a time item that restarts
// the bucket instead zeroes the histogram bin by bin.
// After reset the same histogram clear runs with busy high.
// Results cannot be stalled; done is high in the cycle after the final state, with busy low.
`timescale 1ns / 1ps
`default_nettype none
module unique_advertiser_counter (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire uac_pkg::item_t item,
	output logic done,
	output uac_pkg::result_t result,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [uac_pkg::PADDR_W-1:0] paddr,
	input wire logic [uac_pkg::PDATA_W-1:0] pwdata,
	output logic [uac_pkg::PDATA_W-1:0] prdata,
	output logic pready
);

	logic [uac_pkg::BS_W-1:0] bucket_seconds_q;
	logic reg_hit;
	uac_pkg::cmd_t cmd;
	uac_pkg::status_t status;

	assign pready = 1'b1;
	assign reg_hit = paddr[uac_pkg::PADDR_W-1] == uac_pkg::REG_BUCKET_SECONDS;
	assign prdata = reg_hit ? uac_pkg::PDATA_W'(bucket_seconds_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_seconds_q <= uac_pkg::BS_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			bucket_seconds_q <= pwdata[uac_pkg::BS_W-1:0];
		end
	end

	uac_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.status(status),
		.cmd(cmd),
		.busy(busy),
		.done(done)
	);

	uac_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.item(item),
		.bucket_seconds(bucket_seconds_q),
		.status(status),
		.result(result)
	);

endmodule
`default_nettype wire

// ===== test/unique_advertiser_counter_test.sv =====
// Testbench for the unique advertiser counter: directed and random transactions checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module unique_advertiser_counter_test;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	uac_pkg::item_t item = '0;
	logic done;
	uac_pkg::result_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [uac_pkg::PADDR_W-1:0] paddr = '0;
	logic [uac_pkg::PDATA_W-1:0] pwdata = '0;
	logic [uac_pkg::PDATA_W-1:0] prdata;
	logic pready;

	logic [uac_pkg::ADDR_W-1:0] seen_addr [uac_pkg::TABLE_ENTRIES];
	logic [uac_pkg::RSSI_W-1:0] seen_rssi [uac_pkg::TABLE_ENTRIES];
	int unsigned seen_count = 0;
	logic [uac_pkg::SEC_W-1:0] bucket_origin = '0;
	logic [uac_pkg::BS_W-1:0] bucket_len = uac_pkg::BS_RESET;
	uac_pkg::result_t pending_results [$];
	int unsigned mismatches = 0;
	logic [uac_pkg::SEC_W-1:0] clock_now = 32'd1000;

	unique_advertiser_counter u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	function automatic logic [uac_pkg::RSSI_W-1:0] upper_median();
		int unsigned hist [256];
		int unsigned acc;
		for (int b = 0; b < 256; b++) hist[b] = 0;
		if (seen_count == 0) return '0;
		for (int unsigned e = 0; e < seen_count; e++) hist[seen_rssi[e] ^ 8'h80]++;
		acc = 0;
		for (int b = 0; b < 256; b++) begin
			acc += hist[b];
			if (acc > seen_count / 2) return uac_pkg::RSSI_W'(b) ^ 8'h80;
		end
		return '0;
	endfunction

	function automatic uac_pkg::result_t predict_counter(uac_pkg::item_t it);
		uac_pkg::result_t r;
		logic known;
		r = '0;
		if (it.kind == uac_pkg::KIND_ADV) begin
			known = 1'b0;
			for (int unsigned e = 0; e < seen_count; e++)
				if (seen_addr[e] == it.device_address) known = 1'b1;
			if (!known) begin
				if (seen_count >= uac_pkg::TABLE_ENTRIES) r.dropped_full = 1'b1;
				else begin
					seen_addr[uac_pkg::IDX_W'(seen_count)] = it.device_address;
					seen_rssi[uac_pkg::IDX_W'(seen_count)] = it.signal_strength;
					seen_count++;
					r.added = 1'b1;
				end
			end
		end else begin
			if (bucket_origin == 0) bucket_origin = it.now_seconds;
			if (uac_pkg::SEC_W'(it.now_seconds - bucket_origin) >= {15'd0, bucket_len}) begin
				seen_count = 0;
				bucket_origin = it.now_seconds;
				r.rolled = 1'b1;
			end
		end
		r.unique_count = uac_pkg::CNT_W'(seen_count);
		r.bucket_begin = bucket_origin;
		r.median_strength = upper_median();
		return r;
	endfunction

	always @(posedge clk) begin
		uac_pkg::result_t want;
		if (done) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", result);
			end else begin
				want = pending_results.pop_front();
				if (result !== want) begin
					mismatches++;
					if (mismatches <= 10) $display("expected %p actual %p", want, result);
				end
			end
		end
	end

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
		repeat (n) @(posedge clk);
	endtask

	task automatic send_item(uac_pkg::item_t it, bit gaps);
		uac_pkg::result_t expected;
		item <= it;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected = predict_counter(it);
		pending_results = {pending_results, expected};
		start <= 1'b0;
		@(posedge clk);
		if (gaps) idle_gap();
	endtask

	task automatic drain();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_bucket_len(logic [uac_pkg::BS_W-1:0] v);
		drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= uac_pkg::PADDR_W'({uac_pkg::REG_BUCKET_SECONDS, 2'b00});
		pwdata <= uac_pkg::PDATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		bucket_len = v;
	endtask

	function automatic uac_pkg::item_t adv_item(logic [uac_pkg::ADDR_W-1:0] a,
			logic [uac_pkg::RSSI_W-1:0] s);
		uac_pkg::item_t it;
		it.kind = uac_pkg::KIND_ADV;
		it.device_address = a;
		it.signal_strength = s;
		it.now_seconds = {$urandom};
		return it;
	endfunction

	function automatic uac_pkg::item_t time_item(logic [uac_pkg::SEC_W-1:0] t);
		uac_pkg::item_t it;
		it.kind = uac_pkg::KIND_TIME;
		it.device_address = uac_pkg::ADDR_W'({$urandom, $urandom});
		it.signal_strength = uac_pkg::RSSI_W'($urandom);
		it.now_seconds = t;
		return it;
	endfunction

	task automatic test_directed();
		send_item(adv_item('0, 8'h80), 1'b0);
		send_item(adv_item('1, 8'h7f), 1'b0);
		send_item(adv_item('1, 8'h00), 1'b1);
		send_item(adv_item(48'h123456789abc, 8'hff), 1'b0);
		send_item(time_item(32'd0), 1'b0);
		send_item(time_item(32'd100), 1'b0);
		send_item(adv_item(48'h800000000001, 8'h01), 1'b0);
		send_item(time_item(32'd159), 1'b0);
		send_item(time_item(32'd160), 1'b0);
		send_item(time_item(32'hffffffff), 1'b0);
		send_item(time_item(32'd30), 1'b0);
		send_item(adv_item(48'h00ff00ff00ff, 8'h10), 1'b0);
	endtask

	task automatic test_zero_length();
		write_bucket_len('0);
		send_item(adv_item(48'h5, 8'h22), 1'b0);
		send_item(time_item(32'd7), 1'b0);
		send_item(time_item(32'd7), 1'b0);
		send_item(time_item(32'd0), 1'b0);
	endtask

	task automatic test_full_table();
		write_bucket_len(17'h1ffff);
		send_item(time_item(32'd5000), 1'b0);
		for (int e = 0; e < uac_pkg::TABLE_ENTRIES; e++)
			send_item(adv_item(48'hA00000000000 + uac_pkg::ADDR_W'(e),
				uac_pkg::RSSI_W'($urandom)), $urandom_range(0, 7) == 0);
		send_item(adv_item(48'hBEEF, 8'h11), 1'b0);
		send_item(adv_item(48'hA00000000003, 8'h11), 1'b0);
		send_item(time_item(32'd5000 + 32'h1ffff), 1'b0);
	endtask

	task automatic test_random();
		int rnd;
		logic [uac_pkg::ADDR_W-1:0] a;
		write_bucket_len(17'd40);
		for (int n = 0; n < 48; n++) begin
			if (n == 16) write_bucket_len(17'd86400);
			if (n == 32) write_bucket_len(17'd1);
			if (n == 24) drain();
			rnd = $urandom_range(0, 9);
			if (rnd < 3) begin
				clock_now = clock_now + $urandom_range(0, 30);
				if ($urandom_range(0, 30) == 0) clock_now = {$urandom};
				send_item(time_item(clock_now), 1'b1);
			end else begin
				if (seen_count != 0 && rnd < 5)
					a = seen_addr[uac_pkg::IDX_W'($urandom_range(0, seen_count - 1))];
				else if (rnd < 8) a = 48'(($urandom_range(0, 63)));
				else a = uac_pkg::ADDR_W'({$urandom, $urandom});
				send_item(adv_item(a, uac_pkg::RSSI_W'($urandom)), 1'b1);
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_zero_length();
		test_full_table();
		test_random();
		drain();
		if (mismatches == 0 && pending_results.size() == 0)
			$display("unique_advertiser_counter_test: clean");
		else
			$display("unique_advertiser_counter_test: errors");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("unique_advertiser_counter_test: errors");
		$finish;
	end

endmodule
`default_nettype wire

// ===== unique_advertiser_counter.f =====
src/uac_pkg.sv
src/uac_datapath.sv
src/uac_ctrl.sv
src/unique_advertiser_counter.sv
test/unique_advertiser_counter_test.sv
